// ----- rtl/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Beat structs, opcodes, status codes and the command that drives the cells.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [VAL_W-1:0] value;
    logic [7:0]              position;
  } pol_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic [7:0]              entry_count;
  } pol_out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ----- rtl/pol_cell.sv -----
// ----------------------------------------------------------------------------
// pol_cell: one slot of the list
// Holds one entry; loads the new value, takes a neighbor's entry or holds.
// ----------------------------------------------------------------------------
module pol_cell import pol_pkg::*; (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      CMD_INS: begin
        if (cell_idx == cmd.idx) begin
          data_nxt = cmd.value;
        end else if (cell_idx > cmd.idx) begin
          data_nxt = left_val;
        end
      end
      CMD_DEL: begin
        if (cell_idx >= cmd.idx) begin
          data_nxt = right_val;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign val = data_r;

endmodule

// ----- rtl/pol_ctrl.sv -----
// ----------------------------------------------------------------------------
// pol_ctrl: request decode
// Checks full/empty and position range, builds the cell command and count.
// ----------------------------------------------------------------------------
module pol_ctrl import pol_pkg::*; (
  input  pol_in_t          req,
  input  logic [CNT_W-1:0] count,
  output cell_cmd_t        cmd,
  output status_t          status,
  output logic [CNT_W-1:0] count_nxt
);

  logic       full;
  logic       empty;
  logic [8:0] pos9;
  logic [8:0] cnt9;
  logic [7:0] pos_m1;
  logic [CNT_W-1:0] cnt_m1;

  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);
  assign pos9   = {1'b0, req.position};
  assign cnt9   = 9'(count);
  assign pos_m1 = req.position - 8'd1;
  assign cnt_m1 = count - CNT_W'(1);

  always_comb begin
    cmd.kind  = CMD_HOLD;
    cmd.idx   = '0;
    cmd.value = req.value;
    status    = ST_OK;
    count_nxt = count;
    unique case (op_t'(req.opcode)) inside
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if (op_t'(req.opcode) == OP_INS_POS &&
                     (req.position == 8'd0 || pos9 > cnt9 + 9'd1)) begin
          status = ST_BADPOS;
        end else begin
          cmd.kind  = CMD_INS;
          count_nxt = count + CNT_W'(1);
          if (op_t'(req.opcode) == OP_INS_FRONT) begin
            cmd.idx = '0;
          end else if (op_t'(req.opcode) == OP_INS_BACK) begin
            cmd.idx = count[IDX_W-1:0];
          end else begin
            cmd.idx = pos_m1[IDX_W-1:0];
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (op_t'(req.opcode) == OP_DEL_POS &&
                     (req.position == 8'd0 || pos9 > cnt9)) begin
          status = ST_BADPOS;
        end else begin
          cmd.kind  = CMD_DEL;
          count_nxt = cnt_m1;
          if (op_t'(req.opcode) == OP_DEL_FRONT) begin
            cmd.idx = '0;
          end else if (op_t'(req.opcode) == OP_DEL_BACK) begin
            cmd.idx = cnt_m1[IDX_W-1:0];
          end else begin
            cmd.idx = pos_m1[IDX_W-1:0];
          end
        end
      end
      default: status = ST_BADPOS;
    endcase
  end

endmodule

// ----- rtl/positional_ordered_list_top.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list_top: bounded ordered list on a chain of cells
// Result beat appears in the cycle after the request beat is accepted.
// Throughput: 1 request per cycle unless stalled; each cell shifts, loads or holds at once.
// A new request is taken while the output register is empty or being drained.
// Reset clears the count and output valid; the cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_ordered_list_top import pol_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pol_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pol_out_t out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pol_out_t         out_data_r;
  pol_out_t         out_data_nxt;

  cell_cmd_t        dec_cmd;
  cell_cmd_t        cell_cmd;
  status_t          dec_status;
  logic [CNT_W-1:0] dec_count;
  logic             in_fire;
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0] removed;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  pol_ctrl u_ctrl (
    .req       (in_data),
    .count     (count_r),
    .cmd       (dec_cmd),
    .status    (dec_status),
    .count_nxt (dec_count)
  );

  always_comb begin
    cell_cmd = dec_cmd;
    if (!in_fire) begin
      cell_cmd.kind = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    pol_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .cell_idx  (IDX_W'(i)),
      .left_val  (left_w),
      .right_val (right_w),
      .val       (cell_val[i])
    );
  end

  // Entry leaving the list, read before the chain shifts
  assign removed = (dec_cmd.kind == CMD_DEL) ? cell_val[dec_cmd.idx] : '0;

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      count_nxt                  = dec_count;
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = dec_status;
      out_data_nxt.removed_value = removed;
      out_data_nxt.entry_count   = 8'(dec_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && dec_status != ST_OK |=> count_r == $past(count_r))
    else $error("failed request changed the count");

  a_fail_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && dec_cmd.kind != CMD_DEL |=> out_data_r.removed_value == '0)
    else $error("removed value nonzero without a delete");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.entry_count == 8'(count_r))
    else $error("reported count disagrees with held count");

endmodule

// ----- test/positional_ordered_list_top_tb.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list_top_tb: self-checking bench for the ordered list
// Tracks list contents alongside the block and compares every response beat
// against the predicted status, removed value and count. Directed corner
// beats come first, then random phases that lean toward filling, draining
// or churning the list. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module positional_ordered_list_top_tb;
  import pol_pkg::*;

  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1450;
  localparam int MAX_REPORTS  = 100;

  class list_scoreboard;
    logic signed [VAL_W-1:0] held [CAPACITY];
    int unsigned held_n;
    pol_out_t pending_responses[$];
    int mismatches;
    int accepted;
    int reported;

    function new();
      held_n = 0;
      mismatches = 0;
      accepted = 0;
      reported = 0;
    endfunction

    function void put_at(int unsigned idx, logic signed [VAL_W-1:0] v);
      for (int i = held_n; i > idx; i--) held[i] = held[i-1];
      held[idx] = v;
      held_n++;
    endfunction

    function logic signed [VAL_W-1:0] take_at(int unsigned idx);
      logic signed [VAL_W-1:0] v;
      v = held[idx];
      for (int i = idx; i + 1 < held_n; i++) held[i] = held[i+1];
      held_n--;
      return v;
    endfunction

    // Predict the response to one accepted request beat
    function void note_request(pol_in_t req);
      pol_out_t resp;
      resp = '0;
      resp.status = ST_OK;
      accepted++;
      case (req.opcode) inside
        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
          if (held_n >= CAPACITY) resp.status = ST_FULL;
          else if (req.opcode == OP_INS_FRONT) put_at(0, req.value);
          else if (req.opcode == OP_INS_BACK) put_at(held_n, req.value);
          else if (req.position < 1 || req.position > held_n + 1) resp.status = ST_BADPOS;
          else put_at(req.position - 1, req.value);
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
          if (held_n == 0) resp.status = ST_EMPTY;
          else if (req.opcode == OP_DEL_FRONT) resp.removed_value = take_at(0);
          else if (req.opcode == OP_DEL_BACK) resp.removed_value = take_at(held_n - 1);
          else if (req.position < 1 || req.position > held_n) resp.status = ST_BADPOS;
          else resp.removed_value = take_at(req.position - 1);
        end
        default: resp.status = ST_BADPOS;
      endcase
      resp.entry_count = 8'(held_n);
      pending_responses.push_back(resp);
    endfunction

    function void report(string what, longint exp_v, longint got_v);
      mismatches++;
      if (reported < MAX_REPORTS) begin
        $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
        reported++;
      end
    endfunction

    function void check_result(pol_out_t got);
      pol_out_t exp_r;
      if (pending_responses.size() == 0) begin
        report("unexpected beat, status", -1, got.status);
        return;
      end
      exp_r = pending_responses.pop_front();
      if (got.status !== exp_r.status) report("status", exp_r.status, got.status);
      if (got.removed_value !== exp_r.removed_value)
        report("removed_value", exp_r.removed_value, got.removed_value);
      if (got.entry_count !== exp_r.entry_count)
        report("entry_count", exp_r.entry_count, got.entry_count);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pol_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pol_out_t out_data;

  list_scoreboard sb = new();
  bit sender_quiet;
  bit hold_done;

  positional_ordered_list_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (sender_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(19, 0);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions for the current fill, with some out-of-range ones
  function logic [7:0] pick_position(logic [2:0] op);
    int unsigned lim;
    int r;
    lim = (op == OP_INS_POS) ? sb.held_n + 1 : sb.held_n;
    r = $urandom_range(99, 0);
    if (op != OP_INS_POS && op != OP_DEL_POS) return 8'($urandom_range(255, 0));
    if (r < 80 && lim > 0) return 8'($urandom_range(lim, 1));
    if (r < 88) return 8'd0;
    if (r < 94) return 8'(lim + 1);
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic send_req(logic [2:0] op, logic signed [VAL_W-1:0] val, logic [7:0] pos);
    pol_in_t req;
    int gap;
    req.opcode = op;
    req.value = val;
    req.position = pos;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int ins_pct);
    logic [2:0] op;
    int r;
    r = $urandom_range(99, 0);
    if (r < 3) op = $urandom_range(1, 0) ? OP_RSVD_6 : OP_RSVD_7;
    else if (r < 3 + ins_pct) op = 3'($urandom_range(2, 0));
    else op = 3'($urandom_range(5, 3));
    send_req(op, pick_value(), pick_position(op));
  endtask

  // Response side: random stalls, plus one long hold-off to back up the input
  initial begin
    int l;
    int f;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sb.accepted >= 500) begin
        hold_done = 1'b1;
        l = 300;
      end else begin
        l = $urandom_range(9, 0);
        l = (l < 5) ? 0 : (l < 9) ? $urandom_range(3, 1) : $urandom_range(50, 10);
      end
      f = ($urandom_range(5, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(30, 1);
      if (l > 0) begin
        out_stall <= 1'b1;
        repeat (l) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (f) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int sent;
    int len;
    int ins_pct;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    sender_quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners, reserved opcodes
    send_req(OP_DEL_FRONT, 32'sh5a5a5a5a, 8'd1);
    send_req(OP_DEL_BACK, 32'sh0, 8'd0);
    send_req(OP_DEL_POS, 32'sh0, 8'd0);
    send_req(OP_INS_POS, 32'sh1234, 8'd0);
    send_req(OP_INS_POS, 32'sh1234, 8'd2);
    send_req(OP_RSVD_6, 32'sh0, 8'd1);
    send_req(OP_RSVD_7, -32'sd1, 8'd255);
    // value extremes and edge positions on the way to full
    send_req(OP_INS_POS, 32'sh7fffffff, 8'd1);
    send_req(OP_INS_FRONT, 32'sh80000000, 8'd0);
    send_req(OP_INS_BACK, -32'sd1, 8'd255);
    send_req(OP_INS_POS, 32'sh0, 8'd4);
    send_req(OP_INS_POS, 32'sh0, 8'd255);
    for (int i = 0; i < 12; i++)
      send_req(3'(i % 3), $urandom, 8'(sb.held_n / 2 + 1));
    // full list: full status wins over a bad position
    send_req(OP_INS_FRONT, 32'sh1, 8'd1);
    send_req(OP_INS_BACK, 32'sh1, 8'd1);
    send_req(OP_INS_POS, 32'sh1, 8'd0);
    send_req(OP_DEL_POS, 32'sh0, 8'd0);
    send_req(OP_DEL_POS, 32'sh0, 8'd17);
    send_req(OP_DEL_POS, 32'sh0, 8'd16);
    send_req(OP_DEL_POS, 32'sh0, 8'd1);
    send_req(OP_DEL_BACK, 32'sh0, 8'd0);
    send_req(OP_DEL_FRONT, 32'sh0, 8'd0);

    // random phases: fill-leaning, drain-leaning and balanced
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(3, 0))
        0: ins_pct = 80;
        1: ins_pct = 15;
        default: ins_pct = 48;
      endcase
      sender_quiet = ($urandom_range(3, 0) == 0);
      len = $urandom_range(120, 30);
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        send_random(ins_pct);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #12000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
